@@ design/wrse_pkg.sv @@
// Shared constants, types and helpers of the windowed regression speed estimator.
`timescale 1ns / 1ps
package wrse_pkg;

  localparam int MAX_INTERVALS = 31;
  localparam int RING_DEPTH    = 32;
  localparam int RING_AW       = $clog2(RING_DEPTH);
  localparam int PTS_W         = RING_AW + 1;
  localparam int WIN_W         = 5;
  localparam logic [WIN_W-1:0] WIN_RESET = 5'd8;

  localparam int ANG_W  = 16;
  localparam int TS_W   = 64;
  localparam int UANG_W = 32;

  // accumulator and product widths for up to 32 points with 32-bit offsets
  localparam int SX_W   = 37;
  localparam int SY_W   = 38;
  localparam int SXX_W  = 69;
  localparam int SXY_W  = 70;
  localparam int PRD_W  = 78;
  localparam int MAG_W  = 77;
  localparam int K_W    = 25;
  localparam int MAG_SPLIT = 39;
  localparam int ALO_W  = MAG_SPLIT + K_W;
  localparam int AHI_W  = MAG_W - MAG_SPLIT + K_W;
  localparam int AC_W   = MAG_W + K_W;
  localparam int DIV_W  = 104;
  localparam int DCNT_W = $clog2(DIV_W);

  // milli-rpm per count/us is 29296875 / 32
  localparam logic [K_W-1:0] MRPM_K = 25'd29296875;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_WALK,
    ST_DRAIN,
    ST_CALC,
    ST_DIV,
    ST_PUSH
  } back_state_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle_step;
    logic [PTS_W-1:0]        points;
    logic                    full;
    logic [RING_AW-1:0]      oldest;
    logic [PTS_W-1:0]        n;
  } job_t;

  typedef struct packed {
    logic q_empty;
    logic back_idle;
  } stat_t;

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] addr;
    logic [TS_W-1:0]    ts;
    logic [UANG_W-1:0]  ang;
  } ring_wr_t;

  // number of window points for a register value, clamped to the ring
  function automatic logic [PTS_W-1:0] window_points(input logic [WIN_W-1:0] w);
    logic [8:0] v;
    v = 9'(w);
    if (v == 9'd0) v = 9'd1;
    if (v > 9'(MAX_INTERVALS)) v = 9'(MAX_INTERVALS);
    if (v > 9'(RING_DEPTH - 1)) v = 9'(RING_DEPTH - 1);
    return PTS_W'(v + 9'd1);
  endfunction

endpackage

@@ design/wrse_in_if.sv @@
// Sample channel: wrapped angle and timestamp with valid/ready.
`timescale 1ns / 1ps
interface wrse_in_if;
  logic                          valid;
  logic                          ready;
  logic [wrse_pkg::ANG_W-1:0]    angle;
  logic [wrse_pkg::TS_W-1:0]     timestamp_us;
  modport source (output valid, angle, timestamp_us, input ready);
  modport sink (input valid, angle, timestamp_us, output ready);
endinterface

@@ design/wrse_out_if.sv @@
// Result channel: speed estimate and window status with valid/ready.
`timescale 1ns / 1ps
interface wrse_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [31:0]               speed_mrpm;
  logic                             speed_valid;
  logic signed [wrse_pkg::ANG_W-1:0] angle_step;
  logic [31:0]                      window_span_us;
  logic [wrse_pkg::PTS_W-1:0]       points_in_window;
  modport source (output valid, speed_mrpm, speed_valid, angle_step, window_span_us,
                  points_in_window, input ready);
  modport sink (input valid, speed_mrpm, speed_valid, angle_step, window_span_us,
                points_in_window, output ready);
endinterface

@@ design/wrse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wrse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/wrse_front.sv @@
// Front end: accepts samples, unwraps the angle, writes the ring and queues a job.
`timescale 1ns / 1ps
module wrse_front (
  input  logic                       clk,
  input  logic                       rst,
  wrse_in_if.sink                    sample,
  input  logic                       cfg_we,
  input  logic [wrse_pkg::WIN_W-1:0] cfg_wdata,
  input  wrse_pkg::stat_t            stat,
  output wrse_pkg::ring_wr_t         ring_wr,
  output logic                       push,
  output wrse_pkg::job_t             job
);

  logic [wrse_pkg::WIN_W-1:0]    win_int;
  logic [wrse_pkg::UANG_W-1:0]   run_ang;
  logic [wrse_pkg::ANG_W-1:0]    prev_ang;
  logic                          have_prev;
  logic [wrse_pkg::RING_AW-1:0]  wr_ptr;
  logic [wrse_pkg::PTS_W-1:0]    fill;

  logic                          accept;
  logic [wrse_pkg::PTS_W-1:0]    n;
  logic [wrse_pkg::ANG_W-1:0]    step;
  logic [wrse_pkg::UANG_W-1:0]   run_next;
  logic [wrse_pkg::RING_AW-1:0]  ptr_eff;
  logic [wrse_pkg::RING_AW:0]    ptr_inc;
  logic [wrse_pkg::RING_AW-1:0]  ptr_next;
  logic [wrse_pkg::PTS_W-1:0]    fill_next;

  // take a sample only when the back end has nothing left to read
  assign sample.ready = stat.q_empty && stat.back_idle;
  assign accept       = sample.valid && sample.ready;

  // unwrap and work out the ring position
  always_comb begin
    n         = wrse_pkg::window_points(win_int);
    step      = have_prev ? (sample.angle - prev_ang) : '0;
    run_next  = have_prev ? (run_ang + wrse_pkg::UANG_W'($signed(step))) : '0;
    ptr_eff   = (wrse_pkg::PTS_W'(wr_ptr) >= n) ? '0 : wr_ptr;
    ptr_inc   = (wrse_pkg::RING_AW + 1)'(ptr_eff) + 1'b1;
    ptr_next  = (ptr_inc == n) ? '0 : ptr_inc[wrse_pkg::RING_AW-1:0];
    fill_next = (fill < n) ? (fill + 1'b1) : fill;
  end

  // ring write and job descriptor for the back end
  always_comb begin
    ring_wr.we      = accept;
    ring_wr.addr    = ptr_eff;
    ring_wr.ts      = sample.timestamp_us;
    ring_wr.ang     = run_next;
    push            = accept;
    job.angle_step  = $signed(step);
    job.points      = fill_next;
    job.full        = (fill_next >= n);
    job.oldest      = ptr_next;
    job.n           = n;
  end

  // hold unwrap state and window position
  always_ff @(posedge clk) begin
    if (rst) begin
      win_int   <= wrse_pkg::WIN_RESET;
      run_ang   <= '0;
      prev_ang  <= '0;
      have_prev <= 1'b0;
      wr_ptr    <= '0;
      fill      <= '0;
    end else if (cfg_we) begin
      win_int <= cfg_wdata;
      wr_ptr  <= '0;
      fill    <= '0;
    end else if (accept) begin
      run_ang   <= run_next;
      prev_ang  <= sample.angle;
      have_prev <= 1'b1;
      wr_ptr    <= ptr_next;
      fill      <= fill_next;
    end
  end

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample.ready) else $error("sample accepted with a job in flight");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= wrse_pkg::PTS_W'(wrse_pkg::RING_DEPTH)) else $error("fill count past ring depth");
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (fill == '0) && (wr_ptr == '0)) else $error("window not restarted");
`endif

endmodule

@@ design/wrse_queue.sv @@
// Two-entry job queue between the front and the back end.
`timescale 1ns / 1ps
module wrse_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wrse_pkg::job_t push_job,
  input  logic           pop,
  output wrse_pkg::job_t head,
  output logic           empty
);

  wrse_pkg::job_t mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign empty   = (cnt == 2'd0);
  assign do_push = push && (cnt != 2'd2);
  assign do_pop  = pop && !empty;
  assign head    = mem[rp];

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_job;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ design/wrse_back.sv @@
// Back end: walks the window, forms the least-squares slope and divides it out.
`timescale 1ns / 1ps
module wrse_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  wrse_pkg::job_t                q_head,
  output logic                          q_pop,
  output logic                          back_idle,
  output logic [wrse_pkg::RING_AW-1:0]  rd_addr,
  input  logic [wrse_pkg::TS_W-1:0]     rd_ts,
  input  logic [wrse_pkg::UANG_W-1:0]   rd_ang,
  wrse_out_if.source                    result
);

  typedef enum logic [3:0] {
    CS_NSXX, CS_SXSX, CS_DEN, CS_SXSY, CS_NUM,
    CS_CHK, CS_ALO, CS_AHI, CS_ASUM, CS_DSET
  } calc_step_t;

  wrse_pkg::back_state_t state, state_next;
  calc_step_t            cstep;
  wrse_pkg::job_t        job;

  logic [wrse_pkg::PTS_W-1:0]   k;
  logic [wrse_pkg::RING_AW-1:0] idx;
  logic [wrse_pkg::RING_AW:0]   idx_inc;
  logic                         last_issue;
  logic                         base_pend;
  logic [wrse_pkg::TS_W-1:0]    base_ts;
  logic [wrse_pkg::UANG_W-1:0]  base_ang;

  logic                         p0_v, p0_last;
  logic                         s1_v, s1_last;
  logic                         s2_v, s2_last;
  logic [wrse_pkg::TS_W-1:0]    x64;
  logic                         x_long;
  logic [31:0]                  s1_x;
  logic signed [31:0]           s1_y;
  logic [31:0]                  s2_x;
  logic signed [31:0]           s2_y;
  logic [63:0]                  s2_xx;
  logic signed [63:0]           s2_xy;

  logic [wrse_pkg::SX_W-1:0]         sx;
  logic signed [wrse_pkg::SY_W-1:0]  sy;
  logic [wrse_pkg::SXX_W-1:0]        sxx;
  logic signed [wrse_pkg::SXY_W-1:0] sxy;
  logic                              too_long;
  logic [wrse_pkg::TS_W-1:0]         span64;

  logic signed [wrse_pkg::PRD_W-1:0] t1, t2, den, num;
  logic                              neg;
  logic                              sp_ok;
  logic [wrse_pkg::MAG_W-1:0]        mag;
  logic [wrse_pkg::ALO_W-1:0]        alo;
  logic [wrse_pkg::AHI_W-1:0]        ahi;
  logic [wrse_pkg::AC_W-1:0]         asum;
  logic [wrse_pkg::DIV_W-1:0]        dvd, dvs, rem, quo;
  logic [wrse_pkg::DCNT_W-1:0]       div_cnt;
  logic [wrse_pkg::DIV_W:0]          r_sh;
  logic                              r_ge;
  logic                              calc_ok;
  logic                              out_load;

  logic [31:0]        lim;
  logic [31:0]        sat_m;
  logic signed [31:0] speed_c;
  logic [31:0]        span_c;

  assign back_idle  = (state == wrse_pkg::ST_IDLE);
  assign last_issue = (k == job.n - 1'b1);
  assign idx_inc    = (wrse_pkg::RING_AW + 1)'(idx) + 1'b1;
  assign rd_addr    = (state == wrse_pkg::ST_BASE) ? job.oldest : idx;
  assign x64        = rd_ts - base_ts;
  assign x_long     = (x64[wrse_pkg::TS_W-1:32] != '0);
  assign calc_ok    = !den[wrse_pkg::PRD_W-1] && (den != '0) && (span64 != '0) && !too_long;
  assign r_sh       = {rem, dvd[wrse_pkg::DIV_W-1]};
  assign r_ge       = (r_sh >= {1'b0, dvs});

  // saturate, sign and pack the result
  always_comb begin
    lim     = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat_m   = ((quo[wrse_pkg::DIV_W-1:32] != '0) || (quo[31:0] > lim)) ? lim : quo[31:0];
    speed_c = sp_ok ? $signed(neg ? (32'd0 - sat_m) : sat_m) : '0;
    span_c  = !job.full ? '0 :
              (span64[wrse_pkg::TS_W-1:32] != '0) ? 32'hFFFF_FFFF : span64[31:0];
  end

  // next state and handshakes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    case (state)
      wrse_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = q_head.full ? wrse_pkg::ST_BASE : wrse_pkg::ST_PUSH;
        end
      end
      wrse_pkg::ST_BASE: state_next = wrse_pkg::ST_WALK;
      wrse_pkg::ST_WALK: begin
        if (last_issue) state_next = wrse_pkg::ST_DRAIN;
      end
      wrse_pkg::ST_DRAIN: begin
        if (s2_v && s2_last) state_next = wrse_pkg::ST_CALC;
      end
      wrse_pkg::ST_CALC: begin
        if (cstep == CS_CHK && !calc_ok) begin
          state_next = wrse_pkg::ST_PUSH;
        end else if (cstep == CS_DSET) begin
          state_next = wrse_pkg::ST_DIV;
        end
      end
      wrse_pkg::ST_DIV: begin
        if (div_cnt == wrse_pkg::DCNT_W'(wrse_pkg::DIV_W - 1)) state_next = wrse_pkg::ST_PUSH;
      end
      wrse_pkg::ST_PUSH: begin
        if (!result.valid || result.ready) begin
          out_load   = 1'b1;
          state_next = wrse_pkg::ST_IDLE;
        end
      end
      default: state_next = wrse_pkg::ST_IDLE;
    endcase
  end

  // state, pipeline valids and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wrse_pkg::ST_IDLE;
      p0_v         <= 1'b0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      base_pend    <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      state     <= state_next;
      p0_v      <= (state == wrse_pkg::ST_WALK);
      s1_v      <= p0_v;
      s2_v      <= s1_v;
      base_pend <= (state == wrse_pkg::ST_BASE);
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // take a job
    if (q_pop) begin
      job   <= q_head;
      sp_ok <= 1'b0;
      neg   <= 1'b0;
    end

    // clear sums and start the walk at the oldest point
    if (state == wrse_pkg::ST_BASE) begin
      sx       <= '0;
      sy       <= '0;
      sxx      <= '0;
      sxy      <= '0;
      too_long <= 1'b0;
      k        <= '0;
      idx      <= job.oldest;
      cstep    <= CS_NSXX;
    end

    // issue one ring read a cycle
    if (state == wrse_pkg::ST_WALK) begin
      p0_last <= last_issue;
      k       <= k + 1'b1;
      idx     <= (idx_inc == job.n) ? '0 : idx_inc[wrse_pkg::RING_AW-1:0];
    end

    // latch the oldest point as origin
    if (base_pend) begin
      base_ts  <= rd_ts;
      base_ang <= rd_ang;
    end

    // offsets from the origin
    if (p0_v) begin
      s1_x    <= x_long ? '0 : x64[31:0];
      s1_y    <= $signed(rd_ang - base_ang);
      s1_last <= p0_last;
      if (x_long) too_long <= 1'b1;
      if (p0_last) span64 <= x64;
    end

    // products
    if (s1_v) begin
      s2_x    <= s1_x;
      s2_y    <= s1_y;
      s2_xx   <= 64'(s1_x) * 64'(s1_x);
      s2_xy   <= 64'($signed({1'b0, s1_x}) * s1_y);
      s2_last <= s1_last;
    end

    // accumulate
    if (s2_v) begin
      sx  <= sx + wrse_pkg::SX_W'(s2_x);
      sy  <= sy + wrse_pkg::SY_W'(s2_y);
      sxx <= sxx + wrse_pkg::SXX_W'(s2_xx);
      sxy <= sxy + wrse_pkg::SXY_W'(s2_xy);
    end

    // slope numerator and denominator, one product a step
    if (state == wrse_pkg::ST_CALC) begin
      cstep <= calc_step_t'(cstep + 4'd1);
      case (cstep)
        CS_NSXX: t1 <= $signed(wrse_pkg::PRD_W'(job.n * sxx));
        CS_SXSX: t2 <= $signed(wrse_pkg::PRD_W'(sx * sx));
        CS_DEN: begin
          den <= t1 - t2;
          t1  <= wrse_pkg::PRD_W'($signed({1'b0, job.n}) * sxy);
        end
        CS_SXSY: t2 <= wrse_pkg::PRD_W'($signed({1'b0, sx}) * sy);
        CS_NUM:  num <= t1 - t2;
        CS_CHK: begin
          neg   <= num[wrse_pkg::PRD_W-1];
          mag   <= wrse_pkg::MAG_W'(num[wrse_pkg::PRD_W-1] ? -num : num);
          sp_ok <= calc_ok;
        end
        CS_ALO: alo <= wrse_pkg::ALO_W'(mag[wrse_pkg::MAG_SPLIT-1:0] * wrse_pkg::MRPM_K);
        CS_AHI: ahi <= wrse_pkg::AHI_W'(mag[wrse_pkg::MAG_W-1:wrse_pkg::MAG_SPLIT] *
                                        wrse_pkg::MRPM_K);
        CS_ASUM: asum <= wrse_pkg::AC_W'({ahi, {wrse_pkg::MAG_SPLIT{1'b0}}}) +
                         wrse_pkg::AC_W'(alo);
        CS_DSET: begin
          dvd     <= wrse_pkg::DIV_W'({asum, 1'b0}) + wrse_pkg::DIV_W'({den, 5'b0});
          dvs     <= wrse_pkg::DIV_W'({den, 6'b0});
          rem     <= '0;
          quo     <= '0;
          div_cnt <= '0;
        end
        default: ;
      endcase
    end

    // restoring division, one quotient bit a cycle
    if (state == wrse_pkg::ST_DIV) begin
      rem     <= r_ge ? wrse_pkg::DIV_W'(r_sh - {1'b0, dvs}) : r_sh[wrse_pkg::DIV_W-1:0];
      quo     <= {quo[wrse_pkg::DIV_W-2:0], r_ge};
      dvd     <= {dvd[wrse_pkg::DIV_W-2:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
    end

    // load the output register
    if (out_load) begin
      result.speed_mrpm       <= speed_c;
      result.speed_valid      <= sp_ok;
      result.angle_step       <= job.angle_step;
      result.window_span_us   <= span_c;
      result.points_in_window <= job.points;
    end
  end

`ifndef ASSERT_OFF
  a_div_full: assert property (@(posedge clk) disable iff (rst)
    (state == wrse_pkg::ST_DIV) |-> job.full) else $error("division on a filling window");
  a_valid_span: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.speed_valid) |-> (result.window_span_us != '0))
    else $error("speed published with zero span");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.speed_valid) |-> (result.speed_mrpm == '0))
    else $error("invalid speed not zero");
  a_valid_points: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.speed_valid) |-> (result.points_in_window >= 2))
    else $error("speed published from fewer than two points");
`endif

endmodule

@@ design/windowed_regression_speed_estimator_unit.sv @@
// Top level of the windowed regression speed estimator.
`timescale 1ns / 1ps
// Usage:
//   sample  : valid/ready channel of wrapped angle and microsecond timestamp.
//   result  : valid/ready channel, one transaction per accepted sample, carrying
//             speed in milli-rpm, its valid flag, the angle step, window span
//             and the number of points held.
//   cfg_we / cfg_wdata : write of the window interval count; restarts filling.
// Work per sample:
//   While the window fills the job goes straight to the push state. With a full
//   window of n points there are n ring reads through a three-stage
//   multiply-accumulate, ten product steps and a 104-bit restoring division,
//   one quotient bit a cycle; a window whose slope cannot be formed skips it.
//   One sample is in work at a time; the next is taken once the result has
//   moved to the output register.
// Reset: synchronous; window of 8 intervals, empty ring, no previous angle.
// Stall: a result held by the receiver stays in the output register while the
//   next sample is accepted and worked; its result waits for the register.
module windowed_regression_speed_estimator_unit (
  input  logic                       clk,
  input  logic                       rst,
  wrse_in_if.sink                    sample,
  wrse_out_if.source                 result,
  input  logic                       cfg_we,
  input  logic [wrse_pkg::WIN_W-1:0] cfg_wdata
);

  wrse_pkg::stat_t              stat;
  wrse_pkg::ring_wr_t           ring_wr;
  wrse_pkg::job_t               push_job;
  wrse_pkg::job_t               q_head;
  logic                         push;
  logic                         q_pop;
  logic                         q_empty;
  logic                         back_idle;
  logic [wrse_pkg::RING_AW-1:0] rd_addr;
  logic [wrse_pkg::TS_W-1:0]    rd_ts;
  logic [wrse_pkg::UANG_W-1:0]  rd_ang;

  // status back to the front end
  assign stat.q_empty   = q_empty;
  assign stat.back_idle = back_idle;

  wrse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .ring_wr   (ring_wr),
    .push      (push),
    .job       (push_job)
  );

  wrse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  wrse_ram #(.WIDTH(wrse_pkg::TS_W), .DEPTH(wrse_pkg::RING_DEPTH)) u_time_ring (
    .clk   (clk),
    .we    (ring_wr.we),
    .waddr (ring_wr.addr),
    .wdata (ring_wr.ts),
    .raddr (rd_addr),
    .rdata (rd_ts)
  );

  wrse_ram #(.WIDTH(wrse_pkg::UANG_W), .DEPTH(wrse_pkg::RING_DEPTH)) u_angle_ring (
    .clk   (clk),
    .we    (ring_wr.we),
    .waddr (ring_wr.addr),
    .wdata (ring_wr.ang),
    .raddr (rd_addr),
    .rdata (rd_ang)
  );

  wrse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .back_idle (back_idle),
    .rd_addr   (rd_addr),
    .rd_ts     (rd_ts),
    .rd_ang    (rd_ang),
    .result    (result)
  );

endmodule
